/* hdl/rlc_pkg.sv */
// Shared types, constants and fixed-point helpers for the replace-mode layer compositor.
// Used by rlc_regs, replace_layer_composite_top and the testbench; depends on nothing else.
`default_nettype none

package rlc_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int FIELD_BITS   = 16;
  localparam int PROD_BITS    = 2 * CHANNEL_BITS;
  localparam int EXT_BITS     = (CHANNEL_BITS > FIELD_BITS) ? CHANNEL_BITS : FIELD_BITS;
  localparam int DIV_FIRST    = 6;
  localparam int PIPE_STAGES  = CHANNEL_BITS + 7;
  localparam int ADDR_BITS    = 4;
  localparam int DATA_BITS    = 32;

  typedef logic [CHANNEL_BITS-1:0] ch_t;
  typedef logic [PROD_BITS-1:0]    prod_t;

  localparam ch_t CH_ONE  = '1;
  localparam ch_t CH_HALF = CH_ONE >> 1;

  typedef enum logic [1:0] {
    MODE_UNION,
    MODE_CLIP_BACKDROP,
    MODE_CLIP_LAYER,
    MODE_INTERSECT
  } mode_t;

  localparam logic [1:0] REG_OPACITY = 2'd0;
  localparam logic [1:0] REG_MODE    = 2'd1;
  localparam logic [1:0] REG_MASK_EN = 2'd2;

  typedef struct packed {
    logic [FIELD_BITS-1:0] opacity;
    mode_t                 mode;
    logic                  mask_en;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] backdrop_red;
    logic [FIELD_BITS-1:0] backdrop_green;
    logic [FIELD_BITS-1:0] backdrop_blue;
    logic [FIELD_BITS-1:0] backdrop_alpha;
    logic [FIELD_BITS-1:0] layer_red;
    logic [FIELD_BITS-1:0] layer_green;
    logic [FIELD_BITS-1:0] layer_blue;
    logic [FIELD_BITS-1:0] layer_alpha;
    logic [FIELD_BITS-1:0] mask_value;
    logic                  pixel_last;
  } pix_in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] out_red;
    logic [FIELD_BITS-1:0] out_green;
    logic [FIELD_BITS-1:0] out_blue;
    logic [FIELD_BITS-1:0] out_alpha;
    logic                  result_last;
  } pix_out_t;

  typedef struct packed {
    logic [3:0][CHANNEL_BITS-1:0] bd;
    logic [3:0][CHANNEL_BITS-1:0] ly;
    ch_t                          mask;
    logic                         last;
    ch_t                          op;
    prod_t                        prod;
    prod_t                        nprod;
    ch_t                          na;
    ch_t                          low;
    logic [CHANNEL_BITS:0]        rem;
    ch_t                          quo;
    logic                         qsat;
    logic [2:0][PROD_BITS-1:0]    cprod;
  } pipe_t;

  function automatic ch_t sat_ch(input logic [FIELD_BITS-1:0] v);
    logic [EXT_BITS-1:0] e;
    e = EXT_BITS'(v);
    if (e > EXT_BITS'(CH_ONE)) return CH_ONE;
    return CHANNEL_BITS'(e);
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(input ch_t c);
    logic [EXT_BITS-1:0] e;
    e = EXT_BITS'(c);
    return e[FIELD_BITS-1:0];
  endfunction

  function automatic prod_t mul_half(input ch_t a, input ch_t b);
    return prod_t'(a) * prod_t'(b) + prod_t'(CH_HALF);
  endfunction

  // Division by CH_ONE = 2^N - 1: p = q0*2^N + lo = q0*CH_ONE + (q0 + lo).
  function automatic ch_t fx_round(input prod_t p);
    ch_t                   q0;
    logic [CHANNEL_BITS:0] r;
    q0 = p[PROD_BITS-1:CHANNEL_BITS];
    r  = {1'b0, p[CHANNEL_BITS-1:0]} + {1'b0, q0};
    return q0 + CHANNEL_BITS'(r >= {1'b0, CH_ONE});
  endfunction

  function automatic ch_t abs_diff(input ch_t a, input ch_t b);
    return (a >= b) ? a - b : b - a;
  endfunction

endpackage

`default_nettype wire

/* hdl/rlc_regs.sv */
// Configuration registers of the compositor behind an APB-style port.
// Depends on rlc_pkg for the register indexes and the configuration struct.
`default_nettype none

module rlc_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rlc_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [rlc_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [rlc_pkg::DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output rlc_pkg::cfg_t                       cfg
);
  import rlc_pkg::*;

  logic [1:0] index;
  logic       wr;

  assign index  = paddr[ADDR_BITS-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.opacity <= FIELD_BITS'(CH_ONE);
      cfg.mode    <= MODE_UNION;
      cfg.mask_en <= 1'b0;
    end else if (wr) begin
      unique case (index)
        REG_OPACITY: cfg.opacity <= pwdata[FIELD_BITS-1:0];
        REG_MODE:    cfg.mode    <= mode_t'(pwdata[1:0]);
        REG_MASK_EN: cfg.mask_en <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_OPACITY: prdata = DATA_BITS'(cfg.opacity);
      REG_MODE:    prdata = DATA_BITS'(cfg.mode);
      REG_MASK_EN: prdata = DATA_BITS'(cfg.mask_en);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/replace_layer_composite_top.sv */
// Top level of the replace-mode layer compositor: a pipeline of PIPE_STAGES stages and
// an output register. Depends on rlc_pkg and rlc_regs.
//
//   Channel   Signals                             Direction
//   pixel     pixel_valid, pixel_stall, pixel     in  (backdrop, layer, mask, last)
//   result    result_valid, result_stall, result  out (composited pixel, last)
//   config    psel .. pready                      APB-style register port
//
// One item is accepted per cycle while pixel_stall is low; the colour ratio is formed by
// a one-bit-per-stage divider.
// Reset is synchronous and clears the stage valid bits, result_valid and the configuration registers.
// A stall on the result side fills empty stages first; pixel_stall rises only when
// every stage and the output register hold an item.
`default_nettype none

module replace_layer_composite_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           pixel_valid,
  output logic                                pixel_stall,
  input  wire rlc_pkg::pix_in_t               pixel,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output rlc_pkg::pix_out_t                   result,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rlc_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [rlc_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [rlc_pkg::DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import rlc_pkg::*;

  localparam int LAST = PIPE_STAGES - 1;

  cfg_t                   cfg;
  pipe_t                  s  [PIPE_STAGES];
  pipe_t                  nx [PIPE_STAGES];
  logic [PIPE_STAGES-1:0] v;
  logic [PIPE_STAGES:0]   rdy;
  pix_out_t               result_next;

  rlc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    logic [PIPE_STAGES-1:0] m;
    rdy[PIPE_STAGES] = !result_valid || !result_stall;
    for (int i = 0; i < PIPE_STAGES; i++) begin
      m      = {PIPE_STAGES{1'b1}} << i;
      rdy[i] = rdy[PIPE_STAGES] || !(&(v | ~m));
    end
  end

  assign pixel_stall = !rdy[0];

  always_comb begin
    ch_t                   op_sat;
    ch_t                   q;
    ch_t                   ratio;
    ch_t                   bit_q;
    logic [CHANNEL_BITS:0] sum;
    logic [CHANNEL_BITS:0] t;
    prod_t                 num;
    int                    j;

    nx[0] = '0;
    for (int i = 1; i < PIPE_STAGES; i++) begin
      nx[i] = s[i-1];
    end
    op_sat = sat_ch(cfg.opacity);

    nx[0].bd[0] = sat_ch(pixel.backdrop_red);
    nx[0].bd[1] = sat_ch(pixel.backdrop_green);
    nx[0].bd[2] = sat_ch(pixel.backdrop_blue);
    nx[0].bd[3] = sat_ch(pixel.backdrop_alpha);
    nx[0].ly[0] = sat_ch(pixel.layer_red);
    nx[0].ly[1] = sat_ch(pixel.layer_green);
    nx[0].ly[2] = sat_ch(pixel.layer_blue);
    nx[0].ly[3] = sat_ch(pixel.layer_alpha);
    nx[0].mask  = sat_ch(pixel.mask_value);
    nx[0].last  = pixel.pixel_last;

    nx[1].prod = mul_half(s[0].mask, op_sat);
    nx[1].op   = op_sat;

    nx[2].op = cfg.mask_en ? fx_round(s[1].prod) : s[1].op;

    nx[3].nprod = prod_t'(s[2].op) * prod_t'(s[2].ly[3]);
    case (cfg.mode)
      MODE_UNION:         nx[3].prod = mul_half(abs_diff(s[2].ly[3], s[2].bd[3]), s[2].op);
      MODE_CLIP_BACKDROP: nx[3].prod = mul_half(s[2].bd[3], CH_ONE - s[2].op);
      MODE_CLIP_LAYER:    nx[3].prod = mul_half(s[2].ly[3], s[2].op);
      default:            nx[3].prod = '0;
    endcase

    q   = fx_round(s[3].prod);
    sum = {1'b0, s[3].bd[3]} + {1'b0, q};
    case (cfg.mode)
      MODE_UNION: begin
        if (s[3].ly[3] >= s[3].bd[3]) begin
          nx[4].na = (sum > {1'b0, CH_ONE}) ? CH_ONE : sum[CHANNEL_BITS-1:0];
        end else begin
          nx[4].na = s[3].bd[3] - q;
        end
      end
      MODE_INTERSECT: nx[4].na = '0;
      default:        nx[4].na = q;
    endcase

    num        = s[4].nprod + prod_t'(s[4].na >> 1);
    nx[5].qsat = num[PROD_BITS-1:CHANNEL_BITS] >= s[4].na;
    nx[5].rem  = {1'b0, num[PROD_BITS-1:CHANNEL_BITS]};
    nx[5].low  = num[CHANNEL_BITS-1:0];
    nx[5].quo  = '0;

    for (int k = 0; k < CHANNEL_BITS; k++) begin
      j = DIV_FIRST + k;
      t = {s[j-1].rem[CHANNEL_BITS-1:0], s[j-1].low[CHANNEL_BITS-1]};
      if (t >= {1'b0, s[j-1].na}) begin
        nx[j].rem = t - {1'b0, s[j-1].na};
        bit_q     = ch_t'(1);
      end else begin
        nx[j].rem = t;
        bit_q     = '0;
      end
      nx[j].quo = (s[j-1].quo << 1) | bit_q;
      nx[j].low = s[j-1].low << 1;
    end

    if (s[LAST-1].na == '0) begin
      ratio = s[LAST-1].op;
    end else if (s[LAST-1].qsat) begin
      ratio = CH_ONE;
    end else begin
      ratio = s[LAST-1].quo;
    end
    for (int i = 0; i < 3; i++) begin
      nx[LAST].cprod[i] = mul_half(abs_diff(s[LAST-1].ly[i], s[LAST-1].bd[i]), ratio);
    end
  end

  always_comb begin
    ch_t                   q;
    ch_t                   res [3];
    logic [CHANNEL_BITS:0] sum;
    for (int i = 0; i < 3; i++) begin
      q   = fx_round(s[LAST].cprod[i]);
      sum = {1'b0, s[LAST].bd[i]} + {1'b0, q};
      case (cfg.mode)
        MODE_UNION: begin
          if (s[LAST].ly[i] >= s[LAST].bd[i]) begin
            res[i] = (sum > {1'b0, CH_ONE}) ? CH_ONE : sum[CHANNEL_BITS-1:0];
          end else begin
            res[i] = s[LAST].bd[i] - q;
          end
        end
        MODE_CLIP_BACKDROP: res[i] = s[LAST].bd[i];
        MODE_CLIP_LAYER:    res[i] = s[LAST].ly[i];
        default:            res[i] = '0;
      endcase
    end
    result_next.out_red     = to_field(res[0]);
    result_next.out_green   = to_field(res[1]);
    result_next.out_blue    = to_field(res[2]);
    result_next.out_alpha   = to_field(s[LAST].na);
    result_next.result_last = s[LAST].last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v            <= '0;
      result_valid <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v[0] <= pixel_valid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
      if (rdy[PIPE_STAGES]) begin
        result_valid <= v[LAST];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PIPE_STAGES; i++) begin
      if (rdy[i]) begin
        s[i] <= nx[i];
      end
    end
    if (rdy[PIPE_STAGES]) begin
      result <= result_next;
    end
  end

  // The input side stalls only when the whole pipeline is full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (result_valid && (&v)))
    else $error("input stalled with an empty stage");

  // The divider starts with a partial remainder below the divisor.
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (v[DIV_FIRST-1] && !s[DIV_FIRST-1].qsat) |-> (s[DIV_FIRST-1].rem < {1'b0, s[DIV_FIRST-1].na}))
    else $error("divider entry remainder not below divisor");

  // The final remainder stays below the divisor.
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (v[LAST-1] && !s[LAST-1].qsat) |-> (s[LAST-1].rem < {1'b0, s[LAST-1].na}))
    else $error("divider final remainder not below divisor");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && (v == '0)))
    else $error("item left in pipeline after reset");

endmodule

`default_nettype wire

/* verif/replace_layer_composite_top_tb.sv */
`timescale 1ns / 100ps
// Testbench for replace_layer_composite_top: streams pixel items under random idling on both
// channels and checks every composited pixel against a prediction computed in the bench.
// Depends on rlc_pkg and the compositor RTL.

module replace_layer_composite_top_tb;
  import rlc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASES       = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam longint unsigned ONE = (64'd1 << CHANNEL_BITS) - 64'd1;

  class compositor_scoreboard;
    logic [FIELD_BITS-1:0] opacity;
    mode_t                 mode;
    logic                  mask_en;
    pix_out_t              expected_pixels[$];
    int                    mismatch_count;

    function new();
      opacity        = '1;
      mode           = MODE_UNION;
      mask_en        = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_reg(input logic [1:0] index, input logic [DATA_BITS-1:0] value);
      case (index)
        REG_OPACITY: opacity = value[FIELD_BITS-1:0];
        REG_MODE:    mode    = mode_t'(value[1:0]);
        REG_MASK_EN: mask_en = value[0];
        default: ;
      endcase
    endfunction

    function longint unsigned clamp_one(input longint unsigned v);
      return (v > ONE) ? ONE : v;
    endfunction

    function longint unsigned frac_mul(input longint unsigned a, b);
      return (a * b + ONE / 2) / ONE;
    endfunction

    function longint unsigned frac_lerp(input longint unsigned x, y, t);
      if (y >= x) return clamp_one(x + frac_mul(y - x, t));
      return x - frac_mul(x - y, t);
    endfunction

    function pix_out_t blend_pixel(input pix_in_t px);
      longint unsigned bd[4];
      longint unsigned ly[4];
      longint unsigned res[4];
      longint unsigned op;
      longint unsigned na;
      longint unsigned ratio;
      pix_out_t        r;
      int              i;
      bd[0] = clamp_one(px.backdrop_red);
      bd[1] = clamp_one(px.backdrop_green);
      bd[2] = clamp_one(px.backdrop_blue);
      bd[3] = clamp_one(px.backdrop_alpha);
      ly[0] = clamp_one(px.layer_red);
      ly[1] = clamp_one(px.layer_green);
      ly[2] = clamp_one(px.layer_blue);
      ly[3] = clamp_one(px.layer_alpha);
      for (i = 0; i < 4; i++) res[i] = 0;
      op = clamp_one(opacity);
      if (mask_en) op = frac_mul(op, clamp_one(px.mask_value));
      case (mode)
        MODE_UNION: begin
          na    = frac_lerp(bd[3], ly[3], op);
          ratio = op;
          if (na != 0) ratio = clamp_one((op * ly[3] + na / 2) / na);
          for (i = 0; i < 3; i++) res[i] = frac_lerp(bd[i], ly[i], ratio);
          res[3] = na;
        end
        MODE_CLIP_BACKDROP: begin
          for (i = 0; i < 3; i++) res[i] = bd[i];
          res[3] = frac_mul(bd[3], ONE - op);
        end
        MODE_CLIP_LAYER: begin
          for (i = 0; i < 3; i++) res[i] = ly[i];
          res[3] = frac_mul(ly[3], op);
        end
        default: ;
      endcase
      r.out_red     = FIELD_BITS'(res[0] & ONE);
      r.out_green   = FIELD_BITS'(res[1] & ONE);
      r.out_blue    = FIELD_BITS'(res[2] & ONE);
      r.out_alpha   = FIELD_BITS'(res[3] & ONE);
      r.result_last = px.pixel_last;
      return r;
    endfunction

    function void note_pixel(input pix_in_t px);
      expected_pixels.push_back(blend_pixel(px));
    endfunction

    function void check_result(input pix_out_t got);
      pix_out_t want;
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result item with nothing pending: %h", got);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha ||
          got.result_last !== want.result_last) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected r=%h g=%h b=%h a=%h last=%b, got r=%h g=%h b=%h a=%h last=%b",
                   want.out_red, want.out_green, want.out_blue, want.out_alpha,
                   want.result_last, got.out_red, got.out_green, got.out_blue,
                   got.out_alpha, got.result_last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 pixel_valid;
  logic                 pixel_stall;
  pix_in_t              pixel;
  logic                 result_valid;
  logic                 result_stall;
  pix_out_t             result;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  compositor_scoreboard sb;
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  int                   cycle_count    = 0;

  replace_layer_composite_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("replace_layer_composite_top_tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  function automatic logic [FIELD_BITS-1:0] random_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return FIELD_BITS'($urandom_range(0, 7));
      3: return ~FIELD_BITS'($urandom_range(0, 7));
      default: return FIELD_BITS'($urandom);
    endcase
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    px.backdrop_red   = random_channel();
    px.backdrop_green = random_channel();
    px.backdrop_blue  = random_channel();
    px.backdrop_alpha = random_channel();
    px.layer_red      = random_channel();
    px.layer_green    = random_channel();
    px.layer_blue     = random_channel();
    px.layer_alpha    = random_channel();
    px.mask_value     = random_channel();
    px.pixel_last     = ($urandom_range(0, 7) == 0);
    return px;
  endfunction

  function automatic pix_in_t make_pixel(
    input logic [FIELD_BITS-1:0] br, bg, bb, ba, lr, lg, lb, la, mask,
    input logic last
  );
    pix_in_t px;
    px = '{br, bg, bb, ba, lr, lg, lb, la, mask, last};
    return px;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_pixel(input pix_in_t px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      pixel       <= random_pixel();
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= px;
    do @(posedge clk); while (pixel_stall);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  task automatic quiesce();
    pixel_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({index, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(index, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [FIELD_BITS-1:0] op_value;
    logic [1:0]            mode_value;
    int                    p;
    int                    n;
    rst          = 1'b1;
    pixel_valid  = 1'b0;
    pixel        = '0;
    result_stall = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sb           = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: full opacity, union, masking off.
    send_pixel(make_pixel('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0));
    send_pixel(make_pixel('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1));
    send_pixel(make_pixel('1, '1, '1, '1, '0, '0, '0, '0, '1, 1'b0));
    send_pixel(make_pixel('0, '0, '0, '0, '1, '1, '1, '1, '0, 1'b1));

    // Half opacity: ratio clamp with a tiny layer alpha, zero new alpha, layer below backdrop.
    quiesce();
    write_reg(REG_OPACITY, 32'hFFFF_7FFF);
    send_pixel(make_pixel(16'h1234, 16'hFFFF, 16'h0000, 16'h0000,
                          16'hFFFF, 16'h0000, 16'h8000, 16'h0003, '0, 1'b0));
    send_pixel(make_pixel(16'hFFFF, 16'h0000, 16'h5555, 16'h0000,
                          16'h0000, 16'hFFFF, 16'hAAAA, 16'h0000, '1, 1'b1));
    send_pixel(make_pixel(16'hF000, 16'h8001, 16'h0001, 16'h9C40,
                          16'h0F00, 16'h8000, 16'h0000, 16'h4E20, '1, 1'b0));

    quiesce();
    write_reg(REG_MASK_EN, 32'hFFFF_FFFF);
    write_reg(REG_OPACITY, 32'hABCD_FFFF);
    send_pixel(make_pixel('1, '0, '1, '1, '0, '1, '0, '1, '0, 1'b0));
    send_pixel(make_pixel('1, '0, '1, '1, '0, '1, '0, '1, '1, 1'b1));
    send_pixel(make_pixel(16'h4000, 16'hC000, 16'h0001, 16'h8000,
                          16'hC000, 16'h4000, 16'hFFFE, 16'h2000, 16'h8000, 1'b0));

    quiesce();
    write_reg(REG_MODE, 32'(MODE_CLIP_BACKDROP));
    write_reg(REG_OPACITY, 32'h0000_0000);
    send_pixel(make_pixel('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1));
    send_pixel(random_pixel());
    quiesce();
    write_reg(REG_OPACITY, 32'h0000_FFFF);
    send_pixel(make_pixel('1, '1, '1, '1, '0, '0, '0, '0, '0, 1'b0));
    send_pixel(make_pixel('1, '1, '1, '1, '0, '0, '0, '0, '1, 1'b1));

    quiesce();
    write_reg(REG_MODE, 32'(MODE_CLIP_LAYER));
    send_pixel(make_pixel('0, '0, '0, '0, '1, '1, '1, '1, '1, 1'b0));
    send_pixel(make_pixel('0, '0, '0, '0, '1, '1, '1, '1, '0, 1'b1));
    send_pixel(random_pixel());

    quiesce();
    write_reg(REG_MODE, 32'hFFFF_FFF0 | 32'(MODE_INTERSECT));
    send_pixel(make_pixel('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1));
    send_pixel(make_pixel('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b0));

    for (p = 0; p < PHASES; p++) begin
      quiesce();
      case (p % 4)
        0: op_value = '0;
        1: op_value = '1;
        2: op_value = FIELD_BITS'($urandom);
        default: op_value = FIELD_BITS'($urandom_range(0, 255)) << $urandom_range(0, 8);
      endcase
      mode_value = 2'((p + p / 4) % 4);
      write_reg(REG_OPACITY, {16'($urandom), op_value});
      write_reg(REG_MODE, {30'($urandom), mode_value});
      write_reg(REG_MASK_EN, {31'($urandom), 1'((p / 2) % 2)});
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct  = 28;
          recv_stall_pct = 28;
        end
      endcase
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) send_pixel(random_pixel());
    end

    pixel_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_pixels.size() == 0) begin
      $display("replace_layer_composite_top_tb: PASS");
    end else begin
      $display("replace_layer_composite_top_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rlc_pkg.sv
hdl/rlc_regs.sv
hdl/replace_layer_composite_top.sv
verif/replace_layer_composite_top_tb.sv
